/* sv/bcs_pkg.sv */
// shared types, constants and the digit pattern table for the press counter display
// no dependencies
`default_nettype none

package bcs_pkg;

   localparam int DIGIT_COUNT_DEFAULT = 4;
   localparam int TIMER_WIDTH_DEFAULT = 16;

   localparam int TICK_WIDTH  = 16;
   localparam int TOTAL_WIDTH = 14;
   localparam int SEG_WIDTH   = 8;
   localparam int EN_WIDTH    = 4;
   localparam int CSR_IDX_WIDTH = 2;

   localparam logic [TICK_WIDTH-1:0] DIGIT_TICKS_RESET    = 16'd2;
   localparam logic [TICK_WIDTH-1:0] SAMPLE_TICKS_RESET   = 16'd20;
   localparam logic [TICK_WIDTH-1:0] DEBOUNCE_TICKS_RESET = 16'd10;

   localparam logic [3:0] DIGIT_MAX = 4'd9;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_DIGIT_TICKS    = 2'd0,
      CSR_SAMPLE_TICKS   = 2'd1,
      CSR_DEBOUNCE_TICKS = 2'd2
   } csr_index_type;

   // what the button path decided this tick
   typedef struct packed {
      logic bump;
      logic led_level;
   } btn_status_type;

   // count range for a given number of decades, elaboration only
   function automatic int pow10(input int n);
      int acc;
      acc = 1;
      for (int i = 0; i < n; i++) begin
         acc = acc * 10;
      end
      return acc;
   endfunction

   // segment pattern, bit0 A through bit6 G, point off
   function automatic logic [SEG_WIDTH-1:0] glyph(input logic [3:0] digit);
      logic [SEG_WIDTH-1:0] pat;
      unique case (digit)
         4'd0:    pat = 8'b0011_1111;
         4'd1:    pat = 8'b0000_0110;
         4'd2:    pat = 8'b0101_1011;
         4'd3:    pat = 8'b0100_1111;
         4'd4:    pat = 8'b0110_0110;
         4'd5:    pat = 8'b0110_1101;
         4'd6:    pat = 8'b0111_1101;
         4'd7:    pat = 8'b0000_0111;
         4'd8:    pat = 8'b0111_1111;
         4'd9:    pat = 8'b0110_1111;
         default: pat = 8'b0000_0000;
      endcase
      return pat & 8'h7F;
   endfunction

endpackage

`default_nettype wire

/* sv/button_counter_seven_segment_scan_unit.sv */
// latency: each tick transaction's result is registered and shown the cycle after acceptance
// throughput: one tick per cycle while results are taken; the decade chain, countdowns and glyph
//   lookup are all combinational, and a new tick goes in at the edge where the held result is taken
// reset: synchronous, clears counts, countdowns and scan position, restores tick registers
// top level of the four-digit multiplexed press counter display
// uses bcs_pkg, bcs_decade_cell, bcs_button_ctrl, bcs_scan
`default_nettype none

module button_counter_seven_segment_scan_unit
   import bcs_pkg::*;
#(
   parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT,
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // tick transactions
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_button_level,
   // results
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [SEG_WIDTH-1:0]          rsp_segment_lines,
   output logic [EN_WIDTH-1:0]           rsp_digit_enables,
   output logic                          rsp_led_level,
   output logic [TOTAL_WIDTH-1:0]        rsp_press_total,
   // register writes
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [TICK_WIDTH-1:0]    csr_wdata
);

   localparam int POS_WIDTH   = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam int COUNT_LIMIT = pow10(DIGIT_COUNT);
   localparam int COUNT_WIDTH = $clog2(COUNT_LIMIT);

   // tick registers
   logic [TICK_WIDTH-1:0] digit_ticks_ff, sample_ticks_ff, debounce_ticks_ff;

   // result register
   logic                   rsp_valid_ff;
   logic [SEG_WIDTH-1:0]   seg_ff;
   logic [EN_WIDTH-1:0]    en_ff;
   logic                   led_ff;
   logic [TOTAL_WIDTH-1:0] total_ff;

   // binary mirror of the decade chain, wraps with the top decade's carry
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic                   accept;
   btn_status_type         btn;
   logic [POS_WIDTH-1:0]   scan_pos;
   logic [DIGIT_COUNT:0]   carry;
   logic [3:0]             digit_next [DIGIT_COUNT];
   logic [3:0]             shown_digit;
   logic [EN_WIDTH-1:0]    en_in;

   // a new tick goes in whenever the result slot is free or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ticks_ff    <= DIGIT_TICKS_RESET;
         sample_ticks_ff   <= SAMPLE_TICKS_RESET;
         debounce_ticks_ff <= DEBOUNCE_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_DIGIT_TICKS:    digit_ticks_ff    <= csr_wdata;
            CSR_SAMPLE_TICKS:   sample_ticks_ff   <= csr_wdata;
            CSR_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_wdata;
            default: ; // unknown index, write dropped
         endcase
      end
   end

   // button sampling and debounce
   bcs_button_ctrl #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_button (
      .clock          (clock),
      .reset          (reset),
      .step           (accept),
      .level          (req_button_level),
      .sample_ticks   (sample_ticks_ff),
      .debounce_ticks (debounce_ticks_ff),
      .status         (btn)
   );

   // decade chain: units sit at the highest index, carry ripples toward the thousands
   assign carry[DIGIT_COUNT] = btn.bump;

   for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_decade
      bcs_decade_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .step       (accept),
         .carry_in   (carry[g+1]),
         .carry_out  (carry[g]),
         .digit_next (digit_next[g])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (carry[0]) begin
         count_in = '0;
      end else if (btn.bump) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   // digit scan
   bcs_scan #(
      .DIGIT_COUNT (DIGIT_COUNT),
      .TIMER_WIDTH (TIMER_WIDTH),
      .POS_WIDTH   (POS_WIDTH)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .digit_ticks (digit_ticks_ff),
      .scan_pos    (scan_pos)
   );

   // the display shows the count after this tick's press
   assign shown_digit = digit_next[scan_pos];

   // active low enables, positions past the fourth leave all dark
   always_comb begin
      for (int k = 0; k < EN_WIDTH; k++) begin
         en_in[k] = !((k < DIGIT_COUNT) && (32'(scan_pos) == k));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         seg_ff   <= glyph(shown_digit);
         en_ff    <= en_in;
         led_ff   <= btn.led_level;
         total_ff <= TOTAL_WIDTH'(count_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_segment_lines = seg_ff;
   assign rsp_digit_enables = en_ff;
   assign rsp_led_level     = led_ff;
   assign rsp_press_total   = total_ff;

`ifndef SYNTHESIS
   // at most one digit lit at a time
   a_one_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($countones(~rsp_digit_enables) <= 1))
      else $error("more than one digit enable active");

   // decimal point never driven
   a_point_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_segment_lines[SEG_WIDTH-1] == 1'b0))
      else $error("decimal point lit");

   // a press only counts when the confirming look sees the button low
   a_bump_low: assert property (@(posedge clock) disable iff (reset)
      (accept && btn.bump) |-> !req_button_level)
      else $error("press counted with button released");

   // a counted press always moves the count
   a_count_moves: assert property (@(posedge clock) disable iff (reset)
      (accept && btn.bump) |=> (count_ff != $past(count_ff)))
      else $error("press count did not change");
`endif

endmodule

`default_nettype wire

/* sv/bcs_decade_cell.sv */
// one decimal digit of the press count, takes a carry and hands one to the next decade
// uses bcs_pkg
`default_nettype none

module bcs_decade_cell
   import bcs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic       carry_in,
   output logic            carry_out,
   output logic [3:0]      digit_next
);

   logic [3:0] digit_ff;
   logic [3:0] digit_in;

   always_comb begin
      digit_in  = digit_ff;
      carry_out = 1'b0;
      if (carry_in) begin
         if (digit_ff >= DIGIT_MAX) begin
            digit_in  = 4'd0;
            carry_out = 1'b1;
         end else begin
            digit_in = digit_ff + 4'd1;
         end
      end
   end

   assign digit_next = digit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= 4'd0;
      end else if (step) begin
         digit_ff <= digit_in;
      end
   end

endmodule

`default_nettype wire

/* sv/bcs_button_ctrl.sv */
// button sampling and debounce: periodic sample, falling-edge confirm, led hold
// uses bcs_pkg
`default_nettype none

module bcs_button_ctrl
   import bcs_pkg::*;
#(
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic                  level,
   input  wire logic [TICK_WIDTH-1:0] sample_ticks,
   input  wire logic [TICK_WIDTH-1:0] debounce_ticks,
   output btn_status_type             status
);

   logic                   prev_level_ff, prev_level_in;
   logic                   pending_ff, pending_in;
   logic                   led_ff, led_in;
   logic [TIMER_WIDTH-1:0] sample_cnt_ff, sample_cnt_in;
   logic [TIMER_WIDTH-1:0] confirm_cnt_ff, confirm_cnt_in;
   logic [TIMER_WIDTH-1:0] sample_load, confirm_load;
   logic                   bump;

   // zero acts as one, so the load is the tick count minus one
   assign sample_load  = (sample_ticks == '0) ? '0
                         : TIMER_WIDTH'(sample_ticks - 16'd1);
   assign confirm_load = (debounce_ticks == '0) ? '0
                         : TIMER_WIDTH'(debounce_ticks - 16'd1);

   always_comb begin
      prev_level_in  = prev_level_ff;
      pending_in     = pending_ff;
      led_in         = led_ff;
      sample_cnt_in  = sample_cnt_ff;
      confirm_cnt_in = confirm_cnt_ff;
      bump           = 1'b0;
      priority if (pending_ff) begin
         if (confirm_cnt_ff != '0) begin
            confirm_cnt_in = confirm_cnt_ff - TIMER_WIDTH'(1);
         end else begin
            bump          = !level;
            pending_in    = 1'b0;
            sample_cnt_in = sample_load;
         end
      end else if (sample_cnt_ff != '0) begin
         sample_cnt_in = sample_cnt_ff - TIMER_WIDTH'(1);
      end else begin
         if (!level && prev_level_ff) begin
            pending_in     = 1'b1;
            confirm_cnt_in = confirm_load;
         end else begin
            sample_cnt_in = sample_load;
         end
         led_in        = level;
         prev_level_in = level;
      end
   end

   assign status.bump      = bump;
   assign status.led_level = led_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff  <= 1'b1;
         pending_ff     <= 1'b0;
         led_ff         <= 1'b0;
         sample_cnt_ff  <= '0;
         confirm_cnt_ff <= '0;
      end else if (step) begin
         prev_level_ff  <= prev_level_in;
         pending_ff     <= pending_in;
         led_ff         <= led_in;
         sample_cnt_ff  <= sample_cnt_in;
         confirm_cnt_ff <= confirm_cnt_in;
      end
   end

endmodule

`default_nettype wire

/* sv/bcs_scan.sv */
// digit scan sequencer: dwell countdown and position, most significant digit first
// uses bcs_pkg
`default_nettype none

module bcs_scan
   import bcs_pkg::*;
#(
   parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT,
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT,
   parameter int POS_WIDTH   = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [TICK_WIDTH-1:0] digit_ticks,
   output logic [POS_WIDTH-1:0]       scan_pos
);

   logic [TIMER_WIDTH-1:0] cnt_ff, cnt_in;
   logic [TIMER_WIDTH-1:0] reload_raw, reload, cur;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;

   assign reload_raw = (digit_ticks == '0) ? TIMER_WIDTH'(1) : TIMER_WIDTH'(digit_ticks);
   // a value that truncates to zero still dwells one tick
   assign reload     = (reload_raw == '0) ? TIMER_WIDTH'(1) : reload_raw;
   assign cur        = (cnt_ff == '0) ? reload : cnt_ff;

   always_comb begin
      cnt_in = cur - TIMER_WIDTH'(1);
      pos_in = pos_ff;
      if (cur == TIMER_WIDTH'(1)) begin
         if (pos_ff == POS_WIDTH'(DIGIT_COUNT - 1)) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + POS_WIDTH'(1);
         end
      end
   end

   assign scan_pos = pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         pos_ff <= '0;
      end else if (step) begin
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire
